@@ rtl/core/svm_pkg.sv @@
// Shared constants and types for the sprite VM execute unit.
`default_nettype none
package svm_pkg;
	localparam int MEM_BYTES   = 4096;
	localparam int SCREEN_W    = 64;
	localparam int SCREEN_H    = 32;
	localparam int STACK_DEPTH = 16;
	localparam int PIX_COUNT   = SCREEN_W * SCREEN_H;
	localparam int MEM_AW      = $clog2(MEM_BYTES);
	localparam int PIX_AW      = $clog2(PIX_COUNT);
	localparam int XW          = $clog2(SCREEN_W);
	localparam int YW          = $clog2(SCREEN_H);
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int SPW         = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_WMEM = 2'd1;
	localparam logic [1:0] CMD_RPIX = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_STACK = 2'd2;

	localparam logic [11:0] START_RESET = 12'd512;
	localparam logic [15:0] OP_RET      = 16'h00EE;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [11:0] index_value;
		logic        collision;
		logic        pixel;
		logic [1:0]  status;
	} result_t;
endpackage
`default_nettype wire

@@ rtl/core/svm_frame_mem.sv @@
// Display bitmap: one-bit memory, cleared by a pass over every pixel after reset.
`default_nettype none
module svm_frame_mem import svm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	output logic                   busy,
	input  wire logic              rd_en,
	input  wire logic [PIX_AW-1:0] rd_addr,
	output logic                   rd_data,
	input  wire logic              wr_en,
	input  wire logic [PIX_AW-1:0] wr_addr,
	input  wire logic              wr_data
);
	logic mem [PIX_COUNT];
	logic [PIX_AW-1:0] clr_addr_q;
	logic clr_q;

	always_ff @(posedge clk) begin
		if (clr_q) mem[clr_addr_q] <= 1'b0;
		else if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	// one pixel cleared per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == PIX_AW'(PIX_COUNT - 1)) clr_q <= 1'b0;
		end
	end

	assign busy = clr_q;
endmodule
`default_nettype wire

@@ rtl/core/svm_prog_mem.sv @@
// Program memory: byte wide, one write and one registered read port.
`default_nettype none
module svm_prog_mem import svm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [MEM_AW-1:0] rd_addr,
	output logic [7:0]             rd_data,
	input  wire logic              wr_en,
	input  wire logic [MEM_AW-1:0] wr_addr,
	input  wire logic [7:0]        wr_data
);
	logic [7:0] mem [MEM_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

@@ rtl/core/sprite_vm_execute_unit.sv @@
// Top level of the sprite VM execute unit: sequencer, registers and stack.
//
// Usage: one command word enters on s_axis (tdata: cmd, opcode, addr, data);
// one result word leaves on m_axis (tdata: next_pc, index_value, collision,
// pixel, status). The start address is written on cfg_valid/cfg_ready/
// cfg_data while idle; the write also loads the program counter.
// Steps: a memory write or register opcode passes through EXEC and DONE; a
// pixel read adds PIXQ; DRW does, per row, one sprite byte fetch plus up to
// eight display read-modify-write steps, as set by the single read port of
// the display memory. One word is in work at a time; s_axis_tready is high
// while the input register is empty, also while a result waits on m_axis.
// Reset clears registers and the stack pointer and sets the program counter
// to 512; the display is cleared by a pass over every pixel, and a word
// accepted meanwhile waits in the input register until the pass ends.
// Program memory holds whatever was written. A stalled m_axis holds its word
// in the output register; a new command may be accepted and executed meanwhile.
`default_nettype none
module sprite_vm_execute_unit import svm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // cmd[1:0] opcode[17:2] addr[29:18] data[37:30]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // next_pc, index_value, collision, pixel, status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [11:0] cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_ROWRD, S_ROWWT, S_PIXRD, S_PIXWR, S_PIXQ, S_DONE
	} state_t;

	state_t state_q;
	logic [7:0]  vregs_q [16];
	logic [11:0] index_q, pc_q;
	logic [11:0] stack_q [STACK_DEPTH];
	logic [SPW-1:0] sp_q;
	logic [1:0]  cmd_q;
	logic [15:0] op_q;
	logic [11:0] addr_q;
	logic [7:0]  data_q;
	logic        in_full_q;
	logic [3:0]  row_q;
	logic [2:0]  col_q;
	logic [7:0]  bits_q;
	logic [XW-1:0] x0_q;
	logic [YW-1:0] y0_q;
	logic        hit_q;
	result_t     res_q;
	result_t     out_q;
	logic        out_vld_q;

	logic [3:0] fx, fy, fn;
	logic [7:0] kk, vx, vy;
	logic [11:0] pc2, pc4;
	assign fx = op_q[11:8];
	assign fy = op_q[7:4];
	assign fn = op_q[3:0];
	assign kk = op_q[7:0];
	assign vx = vregs_q[fx];
	assign vy = vregs_q[fy];
	assign pc2 = pc_q + 12'd2;
	assign pc4 = pc_q + 12'd4;

	// memories
	logic pm_rd_en, pm_wr_en;
	logic [MEM_AW-1:0] pm_rd_addr;
	logic [7:0] pm_rd_data;
	logic [11:0] row_addr;
	assign row_addr = index_q + {8'd0, row_q};
	assign pm_rd_addr = row_addr[MEM_AW-1:0];
	assign pm_rd_en = (state_q == S_ROWRD);
	assign pm_wr_en = (state_q == S_EXEC) && (cmd_q == CMD_WMEM)
		&& ({1'b0, addr_q} < 13'(MEM_BYTES));

	svm_prog_mem u_prog (
		.clk, .rd_en(pm_rd_en), .rd_addr(pm_rd_addr), .rd_data(pm_rd_data),
		.wr_en(pm_wr_en), .wr_addr(addr_q[MEM_AW-1:0]), .wr_data(data_q)
	);

	logic [7:0] px_x, px_y;
	logic [PIX_AW-1:0] px_addr;
	logic fb_rd_en, fb_rd_data, fb_wr_en, fb_busy;
	assign px_x = 8'(x0_q) + {5'd0, col_q};
	assign px_y = 8'(y0_q) + {4'd0, row_q};
	assign px_addr = PIX_AW'(px_y[YW-1:0]) * PIX_AW'(SCREEN_W) + PIX_AW'(px_x[XW-1:0]);
	assign fb_rd_en = (state_q == S_PIXRD) ||
		((state_q == S_EXEC) && (cmd_q == CMD_RPIX));
	assign fb_wr_en = (state_q == S_PIXWR);
	logic [PIX_AW-1:0] fb_rd_addr;
	assign fb_rd_addr = (state_q == S_EXEC) ? addr_q[PIX_AW-1:0] : px_addr;

	svm_frame_mem u_frame (
		.clk, .arst_n, .busy(fb_busy),
		.rd_en(fb_rd_en), .rd_addr(fb_rd_addr), .rd_data(fb_rd_data),
		.wr_en(fb_wr_en), .wr_addr(px_addr), .wr_data(~fb_rd_data)
	);

	assign s_axis_tready = !in_full_q;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {4'd0, out_q.status, out_q.pixel, out_q.collision,
		out_q.index_value, out_q.next_pc};

	logic out_free;
	assign out_free = !out_vld_q || m_axis_tready;
	logic pix_active;
	assign pix_active = bits_q[3'd7 - col_q] && (px_x < 8'(SCREEN_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_full_q <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < 16; i++) vregs_q[i] <= '0;
			index_q <= '0;
			pc_q    <= START_RESET;
			sp_q    <= '0;
		end else begin
			if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				in_full_q <= 1'b1;
				cmd_q  <= s_axis_tdata[1:0];
				op_q   <= s_axis_tdata[17:2];
				addr_q <= s_axis_tdata[29:18];
				data_q <= s_axis_tdata[37:30];
			end
			if (cfg_valid && cfg_ready) pc_q <= cfg_data;
			unique case (state_q)
				S_IDLE: if (in_full_q && !fb_busy) begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_q.collision <= 1'b0;
					res_q.pixel     <= 1'b0;
					res_q.status    <= ST_OK;
					res_q.next_pc   <= pc_q;
					res_q.index_value <= index_q;
					state_q <= S_DONE;
					unique case (cmd_q)
						CMD_EXEC: begin
							pc_q <= pc2;
							res_q.next_pc <= pc2;
							unique case (op_q[15:12])
								4'h0: if (op_q != OP_RET) res_q.status <= ST_UNSUP;
								else if (sp_q == '0) res_q.status <= ST_STACK;
								else begin
									sp_q <= sp_q - 1'b1;
									pc_q <= stack_q[STK_AW'(sp_q - 1'b1)];
									res_q.next_pc <= stack_q[STK_AW'(sp_q - 1'b1)];
								end
								4'h1: begin
									pc_q <= op_q[11:0];
									res_q.next_pc <= op_q[11:0];
								end
								4'h2: if (sp_q >= SPW'(STACK_DEPTH)) res_q.status <= ST_STACK;
								else begin
									stack_q[STK_AW'(sp_q)] <= pc2;
									sp_q <= sp_q + 1'b1;
									pc_q <= op_q[11:0];
									res_q.next_pc <= op_q[11:0];
								end
								4'h3: if (vx == kk) begin
									pc_q <= pc4; res_q.next_pc <= pc4;
								end
								4'h4: if (vx != kk) begin
									pc_q <= pc4; res_q.next_pc <= pc4;
								end
								4'h5: if (fn != 4'd0) res_q.status <= ST_UNSUP;
								else if (vx == vy) begin
									pc_q <= pc4; res_q.next_pc <= pc4;
								end
								4'h6: vregs_q[fx] <= kk;
								4'h7: vregs_q[fx] <= vx + kk;
								4'h8: unique case (fn)
									4'd0: vregs_q[fx] <= vy;
									4'd1: vregs_q[fx] <= vx | vy;
									4'd2: vregs_q[fx] <= vx & vy;
									default: res_q.status <= ST_UNSUP;
								endcase
								4'hA: begin
									index_q <= op_q[11:0];
									res_q.index_value <= op_q[11:0];
								end
								4'hD: begin
									x0_q  <= vx[XW-1:0];
									y0_q  <= vy[YW-1:0];
									hit_q <= 1'b0;
									row_q <= '0;
									col_q <= '0;
									state_q <= S_ROWRD;
								end
								default: res_q.status <= ST_UNSUP;
							endcase
						end
						CMD_WMEM: ;
						CMD_RPIX: state_q <= S_PIXQ;
						default: res_q.status <= ST_UNSUP;
					endcase
				end
				S_PIXQ: begin
					res_q.pixel <= fb_rd_data & ({1'b0, addr_q} < 13'(PIX_COUNT));
					state_q <= S_DONE;
				end
				S_ROWRD: begin
					if (row_q == fn || px_y >= 8'(SCREEN_H)) begin
						vregs_q[15] <= {7'd0, hit_q};
						res_q.collision <= hit_q;
						state_q <= S_DONE;
					end else state_q <= S_ROWWT;
				end
				S_ROWWT: begin
					bits_q <= pm_rd_data;
					col_q  <= '0;
					state_q <= S_PIXRD;
				end
				S_PIXRD: begin
					state_q <= pix_active ? S_PIXWR : S_PIXRD;
					if (!pix_active) begin
						col_q <= col_q + 1'b1;
						if (col_q == 3'd7) begin
							row_q <= row_q + 1'b1;
							state_q <= S_ROWRD;
						end
					end
				end
				S_PIXWR: begin
					if (fb_rd_data) hit_q <= 1'b1;
					col_q <= col_q + 1'b1;
					state_q <= S_PIXRD;
					if (col_q == 3'd7) begin
						row_q <= row_q + 1'b1;
						state_q <= S_ROWRD;
					end
				end
				S_DONE: if (out_free) begin
					out_q     <= res_q;
					out_vld_q <= 1'b1;
					in_full_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/svm_checker.sv @@
// Port-level checks for the sprite VM execute unit, bound to the top level.
`default_nettype none
module svm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[27:26] != 2'd3)
		else $error("bad status code");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
		else $error("pad bits set");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind sprite_vm_execute_unit svm_checker u_svm_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_ready
);
`default_nettype wire
